FILE: sv/tgad_pkg.sv
// Shared types and constants for the truecolor Targa pixel decoder.
package tgad_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned BPP_W    = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned OUT_DATA_W = 40;

    // Packet header split point and run bias.
    localparam logic [BYTE_W-1:0] RAW_LIMIT = 8'd128;
    localparam logic [BYTE_W-1:0] RUN_BIAS  = 8'd127;

    localparam logic [BPP_W-1:0] BPP_BGRA = 3'd4;
    localparam logic [BPP_W-1:0] PIX_W3   = 3'd3;
    localparam logic [BPP_W-1:0] PIX_W4   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL = 2'd2;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic                 rle_mode;
        logic [BPP_W-1:0]     pix_size;
        logic [COUNT_W-1:0]   pixel_total;
    } cfg_t;

    typedef struct packed {
        logic                 awaiting_header;
        logic                 packet_is_run;
        byte_t                packet_pixels_left;
        logic [1:0]           byte_in_pixel;
        logic [COUNT_W-1:0]   image_pixels_left;
    } dec_state_t;

    typedef struct packed {
        logic   last;
        byte_t  repeat_res;
        byte_t  alpha;
        byte_t  blue;
        byte_t  green;
        byte_t  red;
    } pixel_t;

endpackage

FILE: sv/tgad_step.sv
// Next-state and pixel assembly logic for one accepted byte.
module tgad_step
    import tgad_pkg::*;
(
    input  cfg_t        cfg,
    input  dec_state_t  state_cur,
    input  byte_t       bytes_cur [3],
    input  byte_t       data_byte,
    input  logic        start_image,
    output dec_state_t  state_next,
    output byte_t       bytes_next [3],
    output logic        emit,
    output pixel_t      pixel
);

    logic [BPP_W-1:0]   pix_width;
    logic [BPP_W-1:0]   bip_inc;
    byte_t              count;
    dec_state_t         st;

    always_comb begin
        pix_width = (cfg.pix_size == BPP_BGRA) ? PIX_W4 : PIX_W3;
        st = state_cur;
        bytes_next = bytes_cur;
        emit = 1'b0;
        count = 8'd1;
        bip_inc = {1'b0, state_cur.byte_in_pixel} + 3'd1;

        if (start_image) begin
            st.awaiting_header    = 1'b1;
            st.packet_is_run      = 1'b0;
            st.packet_pixels_left = '0;
            st.byte_in_pixel      = '0;
            st.image_pixels_left  = cfg.pixel_total;
        end
        bip_inc = {1'b0, st.byte_in_pixel} + 3'd1;

        if (st.image_pixels_left != '0) begin
            if (cfg.rle_mode && st.awaiting_header) begin
                // Packet header byte
                if (data_byte < RAW_LIMIT) begin
                    st.packet_is_run      = 1'b0;
                    st.packet_pixels_left = data_byte + 8'd1;
                end else begin
                    st.packet_is_run      = 1'b1;
                    st.packet_pixels_left = data_byte - RUN_BIAS;
                end
                st.awaiting_header = 1'b0;
                st.byte_in_pixel   = '0;
            end else begin
                if (st.byte_in_pixel != 2'd3) begin
                    bytes_next[st.byte_in_pixel] = data_byte;
                end
                if (bip_inc < pix_width) begin
                    st.byte_in_pixel = bip_inc[1:0];
                end else begin
                    emit = 1'b1;
                    st.byte_in_pixel = '0;
                    if (cfg.rle_mode && st.packet_is_run) begin
                        // Clip the run to what remains of the image
                        if (st.image_pixels_left < {24'd0, st.packet_pixels_left}) begin
                            count = st.image_pixels_left[7:0];
                        end else begin
                            count = st.packet_pixels_left;
                        end
                        st.packet_pixels_left = '0;
                        st.awaiting_header    = 1'b1;
                    end else if (cfg.rle_mode) begin
                        if (st.packet_pixels_left != '0) begin
                            st.packet_pixels_left = st.packet_pixels_left - 8'd1;
                        end
                        if (st.packet_pixels_left == '0) begin
                            st.awaiting_header = 1'b1;
                        end
                    end
                    st.image_pixels_left = st.image_pixels_left - {24'd0, count};
                end
            end
        end

        state_next = st;

        pixel.red        = bytes_next[2];
        pixel.green      = bytes_next[1];
        pixel.blue       = bytes_next[0];
        pixel.alpha      = (pix_width == PIX_W4) ? data_byte : 8'd0;
        pixel.repeat_res = count;
        pixel.last       = (st.image_pixels_left == '0);
    end

endmodule

FILE: sv/tgad_out_stage.sv
// Output register for decoded pixels with stream handshake.
module tgad_out_stage
    import tgad_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  pixel_t                pixel,
    output logic                  can_take,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    logic   valid_reg;
    logic   valid_next;
    pixel_t pixel_reg;

    assign can_take = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (can_take) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (can_take && load) begin
            pixel_reg <= pixel;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {pixel_reg.repeat_res, pixel_reg.alpha, pixel_reg.blue,
                       pixel_reg.green, pixel_reg.red};
    assign m_tlast  = pixel_reg.last;

endmodule

FILE: sv/tga_truecolor_pixel_decoder.sv
// Top level of the truecolor Targa pixel decoder.
//
// Input stream (s_*): one byte of the pixel data field per item; s_tuser
// flags the first byte of an image and reloads the pixel count from the
// pixel_total register. Output stream (m_*): one item per decoded pixel,
// red/green/blue/alpha and a repeat count in m_tdata, m_tlast on the item
// that completes the image. Header bytes and bytes past the last pixel
// give no item.
// Configuration: cfg_index 0 = rle_mode, 1 = pixel size in bytes,
// 2 = pixel_total; always ready, write only between images.
// Latency: the pixel leaves on the cycle after its last byte is accepted.
// Throughput: one byte per cycle unless stalled; the decoder state updates
// on each accepted byte and the output register is the only pipeline stage.
// Reset: clears decoder state and the output valid; no image is active, so
// bytes are dropped until a byte with s_tuser set arrives.
// Stall: while a result waits and m_tready is low, s_tready drops; when the
// receiver takes the result a new byte is accepted in the same cycle.
module tga_truecolor_pixel_decoder
    import tgad_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] start_image
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_res
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    dec_state_t state_reg;
    dec_state_t state_next;
    byte_t      bytes_reg  [3];
    byte_t      bytes_next [3];
    logic       emit;
    logic       accept;
    logic       can_take;
    pixel_t     pixel;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_take;
    assign accept    = s_tvalid && can_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rle_mode    <= 1'b0;
            cfg_reg.pix_size    <= PIX_W3;
            cfg_reg.pixel_total <= 32'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RLE_MODE:    cfg_reg.rle_mode    <= cfg_data[0];
                CFG_BPP:         cfg_reg.pix_size    <= cfg_data[BPP_W-1:0];
                CFG_PIXEL_TOTAL: cfg_reg.pixel_total <= cfg_data;
                default: ;
            endcase
        end
    end

    tgad_step u_step (
        .cfg         (cfg_reg),
        .state_cur   (state_reg),
        .bytes_cur   (bytes_reg),
        .data_byte   (s_tdata),
        .start_image (s_tuser),
        .state_next  (state_next),
        .bytes_next  (bytes_next),
        .emit        (emit),
        .pixel       (pixel)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.awaiting_header    <= 1'b1;
            state_reg.packet_is_run      <= 1'b0;
            state_reg.packet_pixels_left <= '0;
            state_reg.byte_in_pixel      <= '0;
            state_reg.image_pixels_left  <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Color bytes hold until overwritten; no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            bytes_reg <= bytes_next;
        end
    end

    tgad_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept && emit),
        .pixel    (pixel),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: sv/tgad_checker.sv
// Port-level checks for the truecolor Targa pixel decoder, bound to the top level.
module tgad_checker
    import tgad_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A waiting result is not withdrawn
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Repeat count stays within one packet
    a_repeat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39:32] != 8'd0) && (m_tdata[39:32] <= 8'd128))
        else $error("repeat count out of range");

    // Empty output register always takes a byte
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tga_truecolor_pixel_decoder tgad_checker u_tgad_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
